/* hdl/svas_pkg.sv */
// ----------------------------------------------------------------------------
// svas_pkg
// Shared types and constants of the supply voltage average scaler.
// ----------------------------------------------------------------------------
package svas_pkg;

    // field widths
    localparam int SVAS_SAMPLE_W  = 15;
    localparam int SVAS_RESULT_W  = 16;
    localparam int SVAS_DIVISOR_W = 16;

    // default ring depth
    localparam int SVAS_DEPTH = 32;

    // prefill counter
    localparam int SVAS_PREFILL_W = 4;
    localparam logic [SVAS_PREFILL_W-1:0] SVAS_PREFILL_ITEMS = 4'd10;

    // four times the mean is a 17-bit dividend
    localparam int SVAS_SCALE_SHIFT = 2;
    localparam int SVAS_SCALE_W     = SVAS_SAMPLE_W + SVAS_SCALE_SHIFT;

    // register file
    localparam int SVAS_APB_AW  = 3;
    localparam int SVAS_APB_DW  = 32;
    localparam int SVAS_REG_IDX_W = SVAS_APB_AW - 2;
    localparam logic [SVAS_REG_IDX_W-1:0] REG_VOLTAGE_DIVISOR = 1'b0;
    localparam logic [SVAS_DIVISOR_W-1:0] SVAS_DIVISOR_RESET = 16'd467;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN,
        ST_SCALE_GO,
        ST_SCALE,
        ST_OUT
    } svas_state_t;

    // ring commands from the sequencer
    typedef struct packed {
        logic load;
        logic update;
    } svas_ring_ctl_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } svas_div_stat_t;

endpackage

/* hdl/svas_sdiv.sv */
// ----------------------------------------------------------------------------
// svas_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, dividend
// left-aligned in a shift register, step count chosen at start.
// ----------------------------------------------------------------------------
module svas_sdiv #(
    parameter int DIV_W = 20,
    parameter int CNT_W = $clog2(DIV_W + 1)
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [DIV_W-1:0]                      dividend,
    input  logic [svas_pkg::SVAS_DIVISOR_W-1:0]   divisor,
    input  logic [CNT_W-1:0]                      steps,
    output logic [DIV_W-1:0]                      quotient,
    output svas_pkg::svas_div_stat_t              stat
);
    import svas_pkg::*;

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [SVAS_DIVISOR_W-1:0] rem_reg;
    logic [SVAS_DIVISOR_W-1:0] rem_next;
    logic [SVAS_DIVISOR_W-1:0] dv_reg;
    logic [DIV_W-1:0]          dvd_reg;
    logic [DIV_W-1:0]          quo_reg;
    logic [SVAS_DIVISOR_W:0]   trial;
    logic [SVAS_DIVISOR_W:0]   diff;
    logic                      fits;

    // remainder stays below the divisor, so one extra bit covers the trial
    always_comb begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dv_reg};
        diff     = trial - {1'b0, dv_reg};
        rem_next = fits ? diff[SVAS_DIVISOR_W-1:0] : trial[SVAS_DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps - 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dv_reg  <= divisor;
            dvd_reg <= dividend;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/svas_ring.sv */
// ----------------------------------------------------------------------------
// svas_ring
// Sample ring with running window sum. Prefill is tracked by a fill value
// and a count of slots written since, so the memory is never swept.
// ----------------------------------------------------------------------------
module svas_ring #(
    parameter int DEPTH = svas_pkg::SVAS_DEPTH
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  svas_pkg::svas_ring_ctl_t                     ctl,
    input  logic [svas_pkg::SVAS_SAMPLE_W-1:0]           sample,
    input  logic                                         take,
    output logic [svas_pkg::SVAS_SAMPLE_W+$clog2(DEPTH)-1:0] sum
);
    import svas_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = SVAS_SAMPLE_W + PTR_W;
    localparam logic [PTR_W-1:0]  LAST_POS  = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(DEPTH);

    logic [SVAS_SAMPLE_W-1:0]  mem [DEPTH];
    logic [SVAS_SAMPLE_W-1:0]  rd_data_reg;
    logic [SVAS_SAMPLE_W-1:0]  sample_reg;
    logic                      take_reg;
    logic [PTR_W-1:0]          pos_reg,      pos_next, pos_inc;
    logic [SVAS_PREFILL_W-1:0] prefill_reg,  prefill_next;
    logic [FILL_W-1:0]         fill_cnt_reg, fill_cnt_next;
    logic [SVAS_SAMPLE_W-1:0]  fill_val_reg, fill_val_next;
    logic [SUM_W-1:0]          sum_reg,      sum_next;
    logic [SVAS_SAMPLE_W-1:0]  old_val;
    logic                      wr_en;

    // slots not rewritten since the last prefill still hold the fill value
    always_comb begin
        old_val = (fill_cnt_reg == FULL_CNT) ? rd_data_reg : fill_val_reg;
        pos_inc = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    end

    always_comb begin
        pos_next      = pos_reg;
        prefill_next  = prefill_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_val_next = fill_val_reg;
        sum_next      = sum_reg;
        wr_en         = 1'b0;
        if (ctl.update) begin
            if (prefill_reg != '0) begin
                sum_next      = SUM_W'(sample_reg) * DEPTH_SUM;
                fill_val_next = sample_reg;
                fill_cnt_next = take_reg ? FILL_W'(1) : '0;
                prefill_next  = prefill_reg - 1'b1;
            end else if (take_reg) begin
                sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(sample_reg);
                if (fill_cnt_reg != FULL_CNT) begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            if (take_reg) begin
                wr_en    = 1'b1;
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            prefill_reg  <= SVAS_PREFILL_ITEMS;
            fill_cnt_reg <= '0;
            sum_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            prefill_reg  <= prefill_next;
            fill_cnt_reg <= fill_cnt_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_val_reg <= fill_val_next;
        if (ctl.load) begin
            sample_reg <= sample;
            take_reg   <= take;
        end
    end

    // slot at the write position is read on the beat, written in the cycle after
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rd_data_reg <= mem[pos_reg];
        end
        if (wr_en) begin
            mem[pos_reg] <= sample_reg;
        end
    end

    assign sum = sum_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt_reg <= FULL_CNT)
        else $error("fill count beyond ring depth");

    a_prefill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        prefill_reg <= SVAS_PREFILL_ITEMS)
        else $error("prefill counter out of range");

    a_pos_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.update && take_reg |=> pos_reg != $past(pos_reg))
        else $error("ring position did not advance on store");

endmodule

/* hdl/supply_voltage_average_scaler.sv */
// ----------------------------------------------------------------------------
// supply_voltage_average_scaler
// Moving average of supply ADC readings, scaled to tenths of volts.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat carries a 15-bit reading and a store flag.
// The first ten beats after reset load the whole ring with their reading.
// Result channel m_*: one beat per input beat, the window mean times four
// divided by voltage_divisor (zero acts as one), saturated to 16 bits.
// APB port: voltage_divisor at address 0, reset value 467. Write it only
// while the block is idle.
// Per beat: the ring takes the reading, the ring sum is updated, the sum is
// divided by DEPTH, four times the mean is divided by voltage_divisor, and
// the result is loaded. Both divisions run on one bit-serial divider, one
// quotient bit per cycle. A new beat is taken once the previous result is
// in the output register, so one beat is worked on at a time.
// The output register holds its result while m_ready is low; a finished
// item then waits in front of the output register until it frees up, and
// no new input beat is accepted meanwhile. Reset empties the pipeline and
// rearms the prefill; the ring memory itself is not cleared.
// ----------------------------------------------------------------------------
module supply_voltage_average_scaler #(
    parameter int DEPTH = svas_pkg::SVAS_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [svas_pkg::SVAS_APB_AW-1:0]     paddr,
    input  logic [svas_pkg::SVAS_APB_DW-1:0]     pwdata,
    output logic [svas_pkg::SVAS_APB_DW-1:0]     prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [svas_pkg::SVAS_SAMPLE_W-1:0]   s_adc_sample,
    input  logic                                 s_take_sample,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [svas_pkg::SVAS_RESULT_W-1:0]   m_voltage_x10
);
    import svas_pkg::*;

    localparam int SUM_W       = SVAS_SAMPLE_W + $clog2(DEPTH);
    localparam int DIV_W       = (SUM_W > SVAS_SCALE_W) ? SUM_W : SVAS_SCALE_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);
    localparam int SUM_ALIGN   = DIV_W - SUM_W;
    localparam int SCALE_ALIGN = DIV_W - SVAS_SCALE_W;
    localparam logic [CNT_W-1:0] SUM_STEPS   = CNT_W'(SUM_W);
    localparam logic [CNT_W-1:0] SCALE_STEPS = CNT_W'(SVAS_SCALE_W);
    localparam logic [SVAS_DIVISOR_W-1:0] DEPTH_DIV = SVAS_DIVISOR_W'(DEPTH);

    svas_state_t              state_reg, state_next;
    svas_ring_ctl_t           ring_ctl;
    svas_div_stat_t           div_stat;
    logic [SUM_W-1:0]         sum;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [SVAS_DIVISOR_W-1:0] div_divisor;
    logic [CNT_W-1:0]         div_steps;
    logic [DIV_W-1:0]         div_quotient;
    logic [SVAS_SAMPLE_W-1:0] mean_reg;
    logic [SVAS_SCALE_W-1:0]  mean_x4;
    logic [SVAS_DIVISOR_W-1:0] divisor_reg;
    logic [SVAS_DIVISOR_W-1:0] divisor_eff;
    logic [SVAS_RESULT_W-1:0] result_sat;
    logic                     m_valid_reg;
    logic [SVAS_RESULT_W-1:0] m_voltage_reg;
    logic                     out_free;
    logic                     out_load;
    logic                     s_accept;
    logic                     cfg_write;
    logic [SVAS_REG_IDX_W-1:0] reg_idx;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[SVAS_APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= SVAS_DIVISOR_RESET;
        end else if (cfg_write && reg_idx == REG_VOLTAGE_DIVISOR) begin
            divisor_reg <= pwdata[SVAS_DIVISOR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_VOLTAGE_DIVISOR) begin
            prdata = SVAS_APB_DW'(divisor_reg);
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    svas_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ring_ctl),
        .sample  (s_adc_sample),
        .take    (s_take_sample),
        .sum     (sum)
    );

    svas_sdiv #(
        .DIV_W (DIV_W),
        .CNT_W (CNT_W)
    ) u_sdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign mean_x4     = {mean_reg, {SVAS_SCALE_SHIFT{1'b0}}};
    assign divisor_eff = (divisor_reg == '0) ? SVAS_DIVISOR_W'(1) : divisor_reg;
    assign result_sat  = div_quotient[SVAS_SCALE_W-1] ? '1
                                                       : div_quotient[SVAS_RESULT_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MEAN && div_stat.done) begin
            mean_reg <= div_quotient[SVAS_SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid)        state_next = ST_UPDATE;
            ST_UPDATE:                       state_next = ST_MEAN_GO;
            ST_MEAN_GO:                      state_next = ST_MEAN;
            ST_MEAN:     if (div_stat.done)  state_next = ST_SCALE_GO;
            ST_SCALE_GO:                     state_next = ST_SCALE;
            ST_SCALE:    if (div_stat.done)  state_next = ST_OUT;
            ST_OUT:      if (out_free)       state_next = ST_IDLE;
            default:                         state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = 1'b0;
        ring_ctl.load   = 1'b0;
        ring_ctl.update = 1'b0;
        div_start       = 1'b0;
        div_dividend    = DIV_W'(sum) << SUM_ALIGN;
        div_divisor     = DEPTH_DIV;
        div_steps       = SUM_STEPS;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                ring_ctl.load = s_valid;
            end
            ST_UPDATE: begin
                ring_ctl.update = 1'b1;
            end
            ST_MEAN_GO: begin
                div_start = 1'b1;
            end
            ST_SCALE_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(mean_x4) << SCALE_ALIGN;
                div_divisor  = divisor_eff;
                div_steps    = SCALE_STEPS;
            end
            ST_OUT: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_voltage_reg <= result_sat;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_voltage_x10 = m_voltage_reg;

    a_beat_starts_update: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_UPDATE)
        else $error("accepted beat did not start the ring update");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_MEAN || state_reg == ST_SCALE))
        else $error("divider finished outside a division state");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && out_free |=> m_valid && state_reg == ST_IDLE)
        else $error("finished result not presented");

endmodule
